// ----- hdl/bts_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package bts_pkg;
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;
    localparam logic [0:0] REG_TEX_WIDTH  = 1'b0;
    localparam logic [0:0] REG_TEX_HEIGHT = 1'b1;
    localparam int CFG_INDEX_BITS = 1;
    localparam int SIZE_BITS = 9;
endpackage
`default_nettype wire

// ----- hdl/bilinear_texture_sampler.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Bilinear texture sampler.
// Items enter on start while busy is low; busy is tied low, so one item is
// taken every cycle. operation 0 writes one texel (texel_x, texel_y, rgb) into
// the texture memory; operation 1 asks for a filtered sample at (coord_u,
// coord_v). A sample gives one result on red_out/green_out/blue_out, marked
// by done for one cycle; done is registered behind the valid registers of
// stages 1 to 4, in the output register; writes give none.
// Throughput is one item per cycle: the texture is held in four memories
// split by row and column parity, so the four neighbors of a sample are read
// in a single cycle, one port each.
// Pipeline: scale coords; clamp/split and memory read; weights; products;
// sum and round into the output register.
// A write lands in memory in the cycle after acceptance, ahead of any later
// sample's read. Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data)
// sets the texture size in use; cfg_ready is always high.
// Reset clears the pipeline valid bits and sets both sizes to 256; the
// texture memory is not cleared. The receiver cannot stall: results are
// shown for exactly one cycle.
module bilinear_texture_sampler
    import bts_pkg::*;
#(
    parameter int MAX_WIDTH = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int COORD_FRAC_BITS = 16
)(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire logic operation,
    input  wire logic [7:0] texel_x,
    input  wire logic [7:0] texel_y,
    input  wire logic [7:0] red_in,
    input  wire logic [7:0] green_in,
    input  wire logic [7:0] blue_in,
    input  wire logic [16:0] coord_u,
    input  wire logic [16:0] coord_v,
    input  wire logic cfg_valid,
    output logic      cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [SIZE_BITS-1:0] cfg_data,
    output logic      done,
    output logic [7:0] red_out,
    output logic [7:0] green_out,
    output logic [7:0] blue_out
);
    localparam int XB = $clog2(MAX_WIDTH);
    localparam int YB = $clog2(MAX_HEIGHT);
    localparam int HXB = (XB > 1) ? XB - 1 : 1;
    localparam int HYB = (YB > 1) ? YB - 1 : 1;
    localparam int HW = (MAX_WIDTH + 1) / 2;
    localparam int HH = (MAX_HEIGHT + 1) / 2;
    localparam int F = COORD_FRAC_BITS;
    localparam int CB = F + 1;
    localparam int DB = CB + 12;
    localparam int WB = 2 * F + 2;
    localparam int AB = WB + 8 + 2;
    localparam logic [CB-1:0] ONE = CB'(1) << F;
    localparam logic [12:0] MAXW13 = 13'(MAX_WIDTH);
    localparam logic [12:0] MAXH13 = 13'(MAX_HEIGHT);

    assign busy = 1'b0;
    assign cfg_ready = 1'b1;

    logic [SIZE_BITS-1:0] tex_width_reg, tex_height_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_width_reg <= SIZE_BITS'(256);
            tex_height_reg <= SIZE_BITS'(256);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_TEX_WIDTH:  tex_width_reg <= cfg_data;
                REG_TEX_HEIGHT: tex_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    function automatic logic [12:0] clamp_size(input logic [SIZE_BITS-1:0] s,
                                               input logic [12:0] hi);
        logic [12:0] e;
        e = 13'(s);
        if (e < 13'd2) return 13'd2;
        if (e > hi) return hi;
        return e;
    endfunction

    logic [12:0] wm1, hm1;
    always_comb
    begin
        wm1 = clamp_size(tex_width_reg, MAXW13) - 13'd1;
        hm1 = clamp_size(tex_height_reg, MAXH13) - 13'd1;
    end

    // stage 1: accept, saturate, scale
    logic in_fire;
    assign in_fire = start && !busy;
    logic [CB-1:0] cu, cv;
    always_comb
    begin
        cu = (CB'(coord_u) > ONE || (17 > CB && (coord_u >> CB) != 0)) ? ONE : CB'(coord_u);
        cv = (CB'(coord_v) > ONE || (17 > CB && (coord_v >> CB) != 0)) ? ONE : CB'(coord_v);
    end

    logic s1_vld_reg, wr_vld_reg;
    logic [DB-1:0] du_reg, dv_reg;
    logic [12:0] wm1_reg, hm1_reg;
    logic [7:0] wx_reg, wy_reg;
    logic [23:0] wc_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            wr_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= in_fire && operation == OP_SAMPLE;
            wr_vld_reg <= in_fire && operation == OP_WRITE
                && 13'(texel_x) < MAXW13 && 13'(texel_y) < MAXH13;
        end
    end
    always_ff @(posedge clk)
    begin
        du_reg <= DB'(wm1) * DB'(cu);
        dv_reg <= DB'(hm1) * DB'(cv);
        wm1_reg <= wm1;
        hm1_reg <= hm1;
        wx_reg <= texel_x;
        wy_reg <= texel_y;
        wc_reg <= {red_in, green_in, blue_in};
    end

    // stage 2: index clamp and fraction, memory addresses
    logic [DB-1:0] iu, iv, ilu, ilv;
    logic [CB-1:0] fx, fy;
    always_comb
    begin
        iu = du_reg >> F;
        iv = dv_reg >> F;
        ilu = (iu > DB'(wm1_reg - 13'd1)) ? DB'(wm1_reg - 13'd1) : iu;
        ilv = (iv > DB'(hm1_reg - 13'd1)) ? DB'(hm1_reg - 13'd1) : iv;
        fx = CB'(du_reg - (ilu << F));
        fy = CB'(dv_reg - (ilv << F));
    end

    logic [XB:0] xi, xi1;
    logic [YB:0] yi, yi1;
    logic [HXB-1:0] ax_even, ax_odd;
    logic [HYB-1:0] ay_even, ay_odd;
    always_comb
    begin
        xi = (XB+1)'(ilu);
        yi = (YB+1)'(ilv);
        xi1 = xi + 1'b1;
        yi1 = yi + 1'b1;
        // even bank holds the even one of (i, i+1), odd bank the other
        ax_even = xi[0] ? HXB'(xi1 >> 1) : HXB'(xi >> 1);
        ax_odd  = HXB'(xi >> 1);
        ay_even = yi[0] ? HYB'(yi1 >> 1) : HYB'(yi >> 1);
        ay_odd  = HYB'(yi >> 1);
    end

    // four banks by (y parity, x parity)
    logic [23:0] mem00 [HW*HH];
    logic [23:0] mem01 [HW*HH];
    logic [23:0] mem10 [HW*HH];
    logic [23:0] mem11 [HW*HH];
    localparam int ABITS = $clog2(HW*HH) > 0 ? $clog2(HW*HH) : 1;
    logic [ABITS-1:0] waddr;
    assign waddr = ABITS'(HW) * ABITS'(wy_reg >> 1) + ABITS'(wx_reg >> 1);

    function automatic logic [ABITS-1:0] baddr(input logic [HYB-1:0] y,
                                              input logic [HXB-1:0] x);
        return ABITS'(HW) * ABITS'(y) + ABITS'(x);
    endfunction

    logic [23:0] q00_reg, q01_reg, q10_reg, q11_reg;
    always_ff @(posedge clk)
    begin
        if (wr_vld_reg)
        begin
            case ({wy_reg[0], wx_reg[0]})
                2'b00: mem00[waddr] <= wc_reg;
                2'b01: mem01[waddr] <= wc_reg;
                2'b10: mem10[waddr] <= wc_reg;
                default: mem11[waddr] <= wc_reg;
            endcase
        end
        q00_reg <= mem00[baddr(ay_even, ax_even)];
        q01_reg <= mem01[baddr(ay_even, ax_odd)];
        q10_reg <= mem10[baddr(ay_odd, ax_even)];
        q11_reg <= mem11[baddr(ay_odd, ax_odd)];
    end

    logic s2_vld_reg;
    logic [CB-1:0] fx_reg, fy_reg;
    logic px_reg, py_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s2_vld_reg <= 1'b0;
        else s2_vld_reg <= s1_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        fx_reg <= fx;
        fy_reg <= fy;
        px_reg <= xi[0];
        py_reg <= yi[0];
    end

    // stage 3: route banks to corners, weights
    logic [23:0] c00, c10, c01, c11, re0, re1, ro0, ro1;
    always_comb
    begin
        // rows: j even -> row j in even banks
        re0 = py_reg ? q10_reg : q00_reg;
        re1 = py_reg ? q11_reg : q01_reg;
        ro0 = py_reg ? q00_reg : q10_reg;
        ro1 = py_reg ? q01_reg : q11_reg;
        c00 = px_reg ? re1 : re0;
        c10 = px_reg ? re0 : re1;
        c01 = px_reg ? ro1 : ro0;
        c11 = px_reg ? ro0 : ro1;
    end

    logic s3_vld_reg;
    logic [WB-1:0] w00_reg, w10_reg, w01_reg, w11_reg;
    logic [23:0] c00_reg, c10_reg, c01_reg, c11_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s3_vld_reg <= 1'b0;
        else s3_vld_reg <= s2_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        w00_reg <= WB'(ONE - fx_reg) * WB'(ONE - fy_reg);
        w10_reg <= WB'(fx_reg) * WB'(ONE - fy_reg);
        w01_reg <= WB'(ONE - fx_reg) * WB'(fy_reg);
        w11_reg <= WB'(fx_reg) * WB'(fy_reg);
        c00_reg <= c00;
        c10_reg <= c10;
        c01_reg <= c01;
        c11_reg <= c11;
    end

    // stage 4: products
    logic s4_vld_reg;
    logic [AB-1:0] p_reg [3][4];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s4_vld_reg <= 1'b0;
        else s4_vld_reg <= s3_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            p_reg[ch][0] <= AB'(c00_reg[16-8*ch +: 8]) * AB'(w00_reg);
            p_reg[ch][1] <= AB'(c10_reg[16-8*ch +: 8]) * AB'(w10_reg);
            p_reg[ch][2] <= AB'(c01_reg[16-8*ch +: 8]) * AB'(w01_reg);
            p_reg[ch][3] <= AB'(c11_reg[16-8*ch +: 8]) * AB'(w11_reg);
        end
    end

    // stage 5: sum, round, saturate
    logic [AB-1:0] acc [3];
    logic [7:0] res [3];
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            acc[ch] = (p_reg[ch][0] + p_reg[ch][1] + p_reg[ch][2] + p_reg[ch][3]
                + (AB'(1) << (2*F - 1))) >> (2*F);
            res[ch] = (acc[ch] > AB'(255)) ? 8'hFF : acc[ch][7:0];
        end
    end

    logic done_reg;
    logic [7:0] r_reg, g_reg, b_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) done_reg <= 1'b0;
        else done_reg <= s4_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        r_reg <= res[0];
        g_reg <= res[1];
        b_reg <= res[2];
    end
    assign done = done_reg;
    assign red_out = r_reg;
    assign green_out = g_reg;
    assign blue_out = b_reg;

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s4_vld_reg |=> done) else $error("result lost in last stage");
    a_sample_path: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && operation == OP_SAMPLE) |=> s1_vld_reg)
        else $error("sample not entered");
    a_no_both: assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_vld_reg && wr_vld_reg)) else $error("write and sample in one stage");
endmodule
`default_nettype wire
